### src/tha_pkg.sv
`default_nettype none
package tha_pkg;

    // Field widths
    localparam int SEC_W         = 2;
    localparam int VALUE_W       = 16;
    localparam int WORD_W        = 64;
    localparam int BITMAP_W      = 66;
    localparam int POS_W         = 7;
    localparam int VCOUNT_W      = 16;
    localparam int COUNT_BITS_DEF = 16;

    // APB register map
    localparam int APB_ADDR_W    = 2;
    localparam int APB_DATA_W    = 32;
    localparam logic [APB_ADDR_W-1:0] REG_GREASE_MARKING = 2'd0;

    // Section codes
    localparam logic [SEC_W-1:0] SEC_CIPHER = 2'd0;
    localparam logic [SEC_W-1:0] SEC_EXT    = 2'd1;
    localparam logic [SEC_W-1:0] SEC_CURVE  = 2'd2;
    localparam logic [SEC_W-1:0] SEC_PF     = 2'd3;

    typedef struct packed {
        logic [SEC_W-1:0]   cmd;
        logic [VALUE_W-1:0] item_value;
        logic               list_empty;
        logic               list_had_grease;
        logic               last_of_list;
    } t_in_item;

    typedef struct packed {
        logic [SEC_W-1:0]    out_section;
        logic                word_index;
        logic [WORD_W-1:0]   bitmap_word;
        logic [VCOUNT_W-1:0] value_count;
        logic                grease_mark;
        logic                last_word;
    } t_out_item;

    // Per-item lookup outcome
    typedef struct packed {
        logic             set_bit;
        logic [POS_W-1:0] pos;
        logic             bump;
    } t_mark;

    // Finished section waiting for the output side
    typedef struct packed {
        logic [SEC_W-1:0]    sec;
        logic [BITMAP_W-1:0] bits;
        logic [VCOUNT_W-1:0] cnt;
        logic                mark;
    } t_res;

    // GREASE: both bytes equal, each of the form 0x?A
    function automatic logic grease_pattern(input logic [VALUE_W-1:0] v);
        return ((v & 16'h0F0F) == 16'h0A0A) && (v[15:8] == v[7:0]);
    endfunction

    function automatic logic [POS_W-1:0] pos_cipher(input logic [VALUE_W-1:0] v);
        logic [POS_W-1:0] p;
        case (v)
            16'hC02F: p = 7'd1;   16'hC02B: p = 7'd2;   16'hC02C: p = 7'd3;
            16'hC030: p = 7'd4;   16'hC013: p = 7'd5;   16'hC014: p = 7'd6;
            16'h1302: p = 7'd7;   16'h1301: p = 7'd8;   16'hCCA8: p = 7'd9;
            16'hCCA9: p = 7'd10;  16'h002F: p = 7'd11;  16'h009C: p = 7'd12;
            16'h0035: p = 7'd13;  16'h009D: p = 7'd14;  16'h1303: p = 7'd15;
            16'hC009: p = 7'd16;  16'hC00A: p = 7'd17;  16'hC027: p = 7'd18;
            16'hC023: p = 7'd19;  16'hC028: p = 7'd20;  16'hC024: p = 7'd21;
            16'h003C: p = 7'd22;  16'h003D: p = 7'd23;  16'h000A: p = 7'd24;
            16'h009E: p = 7'd25;  16'h009F: p = 7'd26;  16'hC012: p = 7'd27;
            16'hC008: p = 7'd28;  16'hCCAA: p = 7'd29;  16'h00FF: p = 7'd30;
            16'h0033: p = 7'd31;  16'h0039: p = 7'd32;  16'h0067: p = 7'd33;
            16'h006B: p = 7'd34;  16'h0032: p = 7'd35;  16'h0038: p = 7'd36;
            16'h0040: p = 7'd37;  16'h006A: p = 7'd38;  16'h00A2: p = 7'd39;
            16'h00A3: p = 7'd40;  16'hC0AD: p = 7'd41;  16'hC0AC: p = 7'd42;
            16'hC09D: p = 7'd43;  16'hC09C: p = 7'd44;  16'hC09F: p = 7'd45;
            16'hC09E: p = 7'd46;  16'hC0AF: p = 7'd47;  16'hC0AE: p = 7'd48;
            16'hC0A1: p = 7'd49;  16'hC0A0: p = 7'd50;  16'hC0A3: p = 7'd51;
            16'hC0A2: p = 7'd52;  16'hC004: p = 7'd53;  16'hC00E: p = 7'd54;
            16'hC025: p = 7'd55;  16'hC029: p = 7'd56;  16'hC02D: p = 7'd57;
            16'hC031: p = 7'd58;  16'hC005: p = 7'd59;  16'hC00F: p = 7'd60;
            16'hC026: p = 7'd61;  16'hC02A: p = 7'd62;  16'hC02E: p = 7'd63;
            16'hC032: p = 7'd64;  16'h1304: p = 7'd65;
            default:  p = 7'd0;
        endcase
        return p;
    endfunction

    function automatic logic [POS_W-1:0] pos_ext(input logic [VALUE_W-1:0] v);
        logic [POS_W-1:0] p;
        case (v)
            16'h000A: p = 7'd1;   16'h000D: p = 7'd2;   16'h0000: p = 7'd3;
            16'h0017: p = 7'd4;   16'h000B: p = 7'd5;   16'h002B: p = 7'd6;
            16'h0033: p = 7'd7;   16'hFF01: p = 7'd8;   16'h002D: p = 7'd9;
            16'h0005: p = 7'd10;  16'h0010: p = 7'd11;  16'h0023: p = 7'd12;
            16'h0012: p = 7'd13;  16'h0015: p = 7'd14;  16'h001B: p = 7'd15;
            16'h0029: p = 7'd16;  16'h0031: p = 7'd17;  16'h0032: p = 7'd18;
            16'h0016: p = 7'd19;  16'h3374: p = 7'd20;  16'h000F: p = 7'd21;
            16'h0011: p = 7'd22;  16'h0018: p = 7'd23;  16'h001C: p = 7'd24;
            default:  p = 7'd0;
        endcase
        return p;
    endfunction

    function automatic logic [POS_W-1:0] pos_curve(input logic [VALUE_W-1:0] v);
        logic [POS_W-1:0] p;
        case (v)
            16'h0017: p = 7'd1;   16'h0018: p = 7'd2;   16'h001D: p = 7'd3;
            16'h0019: p = 7'd4;   16'h11EC: p = 7'd5;   16'h001E: p = 7'd6;
            16'h0100: p = 7'd7;   16'h0101: p = 7'd8;   16'h0102: p = 7'd9;
            16'h0103: p = 7'd10;  16'h0104: p = 7'd11;  16'h6399: p = 7'd12;
            16'h0016: p = 7'd13;  16'h0009: p = 7'd14;  16'h000B: p = 7'd15;
            16'h000A: p = 7'd16;  16'h000C: p = 7'd17;  16'h000D: p = 7'd18;
            16'h000E: p = 7'd19;  16'h001A: p = 7'd20;  16'h001B: p = 7'd21;
            16'h001C: p = 7'd22;  16'h0015: p = 7'd23;  16'h0013: p = 7'd24;
            16'h0001: p = 7'd25;  16'h0003: p = 7'd26;  16'hFE32: p = 7'd27;
            16'h11EB: p = 7'd28;  16'h11ED: p = 7'd29;  16'h4138: p = 7'd30;
            default:  p = 7'd0;
        endcase
        return p;
    endfunction

    // Point formats: 0xFF sits at position 0, so it maps like a miss
    function automatic logic [POS_W-1:0] pos_pf(input logic [7:0] v);
        logic [POS_W-1:0] p;
        case (v)
            8'h00:   p = 7'd1;
            8'h01:   p = 7'd2;
            8'h02:   p = 7'd3;
            default: p = 7'd0;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

### src/tls_hello_anchor_bitmap.sv
`default_nettype none
// Path: a section end passes the input register, then the result register, before its
//   first word is valid; the second cipher word follows once the first is taken.
// Throughput: one item per cycle, except that a section end waits in the input register
//   while the result register is busy; a cipher section end sends two words, every other
//   section end one, through the single result register.
// Reset: synchronous active-low; clears bitmap, count, grease_marking and valids.
module tls_hello_anchor_bitmap #(
    parameter int COUNT_BITS = tha_pkg::COUNT_BITS_DEF
) (
    input  var logic                          i_clk,
    input  var logic                          i_rst_n,
    input  var logic                          i_in_valid,
    output var logic                          o_in_ready,
    input  var tha_pkg::t_in_item             i_in_data,
    output var logic                          o_out_valid,
    input  var logic                          i_out_ready,
    output var tha_pkg::t_out_item            o_out_data,
    input  var logic                          psel,
    input  var logic                          penable,
    input  var logic                          pwrite,
    input  var logic [tha_pkg::APB_ADDR_W-1:0] paddr,
    input  var logic [tha_pkg::APB_DATA_W-1:0] pwdata,
    output var logic [tha_pkg::APB_DATA_W-1:0] prdata,
    output var logic                          pready
);
    import tha_pkg::*;

    logic                  r_grease_marking;
    logic                  r_in_vld;
    t_in_item              r_in;
    logic [BITMAP_W-1:0]   r_bits;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [BITMAP_W-1:0]   n_bits;
    logic [COUNT_BITS-1:0] n_cnt;
    logic [COUNT_BITS+VCOUNT_W-1:0] w_cnt_ext;
    t_mark                 w_mark;
    t_res                  w_res;
    logic                  w_go;
    logic                  w_load;
    logic                  w_free;

    // APB register
    assign pready = 1'b1;
    assign prdata = (paddr == REG_GREASE_MARKING) ?
                    {{(APB_DATA_W-1){1'b0}}, r_grease_marking} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grease_marking <= 1'b0;
        end else if (psel && penable && pwrite && paddr == REG_GREASE_MARKING) begin
            r_grease_marking <= pwdata[0];
        end
    end

    // Input register: a section end waits only for the result register
    assign w_go       = r_in_vld && (!r_in.last_of_list || w_free);
    assign w_load     = w_go && r_in.last_of_list;
    assign o_in_ready = !r_in_vld || w_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    tha_anchor u_anchor (
        .i_item (r_in),
        .o_mark (w_mark)
    );

    // Bitmap and saturating count update
    always_comb begin
        n_bits = r_bits;
        if (w_mark.set_bit) begin
            n_bits = r_bits | (BITMAP_W'(1) << w_mark.pos);
        end
        n_cnt = r_cnt;
        if (w_mark.bump && (r_cnt != {COUNT_BITS{1'b1}})) begin
            n_cnt = r_cnt + {{(COUNT_BITS-1){1'b0}}, 1'b1};
        end
    end

    // Section result, count clipped to the output width
    always_comb begin
        w_cnt_ext  = {{VCOUNT_W{1'b0}}, n_cnt};
        w_res.sec  = r_in.cmd;
        w_res.bits = n_bits;
        w_res.cnt  = (|w_cnt_ext[COUNT_BITS+VCOUNT_W-1:VCOUNT_W]) ?
                     {VCOUNT_W{1'b1}} : w_cnt_ext[VCOUNT_W-1:0];
        w_res.mark = (r_in.cmd != SEC_PF) && r_grease_marking && r_in.list_had_grease;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
            r_cnt  <= '0;
        end else if (w_go) begin
            if (r_in.last_of_list) begin
                r_bits <= '0;
                r_cnt  <= '0;
            end else begin
                r_bits <= n_bits;
                r_cnt  <= n_cnt;
            end
        end
    end

    tha_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_res   (w_res),
        .o_free  (w_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_data)
    );

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_vld && r_in.last_of_list && !w_free))
        else $error("input stalled without a pending section end");
    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_bits == '0 && r_cnt == '0))
        else $error("state not cleared after section end");
    a_end_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_out_valid)
        else $error("section end produced no result");

endmodule
`default_nettype wire

### src/tha_anchor.sv
`default_nettype none
// Per-item classification: grease drop, count bump and anchor position
module tha_anchor (
    input  var tha_pkg::t_in_item i_item,
    output var tha_pkg::t_mark    o_mark
);
    import tha_pkg::*;

    logic             w_grease;
    logic [POS_W-1:0] w_pos;

    assign w_grease = grease_pattern(i_item.item_value);

    // Section table select
    always_comb begin
        case (i_item.cmd)
            SEC_CIPHER: w_pos = pos_cipher(i_item.item_value);
            SEC_EXT:    w_pos = pos_ext(i_item.item_value);
            SEC_CURVE:  w_pos = pos_curve(i_item.item_value);
            SEC_PF:     w_pos = pos_pf(i_item.item_value[7:0]);
            default:    w_pos = '0;
        endcase
    end

    // Empty point-format list marks position 0; other empty lists mark nothing
    always_comb begin
        if (i_item.list_empty) begin
            o_mark.set_bit = (i_item.cmd == SEC_PF);
            o_mark.pos     = '0;
            o_mark.bump    = 1'b0;
        end else if (i_item.cmd == SEC_PF) begin
            o_mark.set_bit = 1'b1;
            o_mark.pos     = w_pos;
            o_mark.bump    = 1'b1;
        end else begin
            o_mark.set_bit = !w_grease;
            o_mark.pos     = w_pos;
            o_mark.bump    = !w_grease;
        end
    end

endmodule
`default_nettype wire

### src/tha_outbuf.sv
`default_nettype none
// Result register: holds one finished section and sends it as one or two words
module tha_outbuf (
    input  var logic               i_clk,
    input  var logic               i_rst_n,
    input  var logic               i_load,
    input  var tha_pkg::t_res      i_res,
    output var logic               o_free,
    output var logic               o_valid,
    input  var logic               i_ready,
    output var tha_pkg::t_out_item o_item
);
    import tha_pkg::*;

    logic r_vld;
    logic r_word;
    t_res r_res;
    logic w_last;

    // Ciphers carry 66 bits and need a second word
    assign w_last  = (r_res.sec != SEC_CIPHER) || r_word;
    assign o_free  = !r_vld || (i_ready && w_last);
    assign o_valid = r_vld;

    always_comb begin
        o_item.out_section = r_res.sec;
        o_item.word_index  = r_word;
        o_item.bitmap_word = r_word ?
            {{(WORD_W-(BITMAP_W-WORD_W)){1'b0}}, r_res.bits[BITMAP_W-1:WORD_W]} :
            r_res.bits[WORD_W-1:0];
        o_item.value_count = r_res.cnt;
        o_item.grease_mark = r_res.mark;
        o_item.last_word   = w_last;
    end

    // Control: valid and word pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_word <= 1'b0;
        end else if (i_load) begin
            r_vld  <= 1'b1;
            r_word <= 1'b0;
        end else if (r_vld && i_ready) begin
            if (w_last) begin
                r_vld <= 1'b0;
            end else begin
                r_word <= 1'b1;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("result register loaded while occupied");
    a_word1_cipher: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && r_word) |-> (r_res.sec == SEC_CIPHER))
        else $error("second word for a non-cipher section");
    a_word_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && i_ready && !w_last && !i_load) |=> (r_vld && r_word))
        else $error("second cipher word lost");

endmodule
`default_nettype wire

### sim/tls_hello_anchor_bitmap_test.sv
`default_nettype none
module tls_hello_anchor_bitmap_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tha_pkg::*;

    localparam int COUNT_W     = COUNT_BITS_DEF;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;

    // Anchor tables, entry 0 first (entry 0 is never matched)
    localparam logic [66*16-1:0] CIPHER_TAB = {
        16'h0000, 16'hC02F, 16'hC02B, 16'hC02C, 16'hC030, 16'hC013, 16'hC014, 16'h1302,
        16'h1301, 16'hCCA8, 16'hCCA9, 16'h002F, 16'h009C, 16'h0035, 16'h009D, 16'h1303,
        16'hC009, 16'hC00A, 16'hC027, 16'hC023, 16'hC028, 16'hC024, 16'h003C, 16'h003D,
        16'h000A, 16'h009E, 16'h009F, 16'hC012, 16'hC008, 16'hCCAA, 16'h00FF, 16'h0033,
        16'h0039, 16'h0067, 16'h006B, 16'h0032, 16'h0038, 16'h0040, 16'h006A, 16'h00A2,
        16'h00A3, 16'hC0AD, 16'hC0AC, 16'hC09D, 16'hC09C, 16'hC09F, 16'hC09E, 16'hC0AF,
        16'hC0AE, 16'hC0A1, 16'hC0A0, 16'hC0A3, 16'hC0A2, 16'hC004, 16'hC00E, 16'hC025,
        16'hC029, 16'hC02D, 16'hC031, 16'hC005, 16'hC00F, 16'hC026, 16'hC02A, 16'hC02E,
        16'hC032, 16'h1304
    };
    localparam logic [25*16-1:0] EXT_TAB = {
        16'hFFFF, 16'h000A, 16'h000D, 16'h0000, 16'h0017, 16'h000B, 16'h002B, 16'h0033,
        16'hFF01, 16'h002D, 16'h0005, 16'h0010, 16'h0023, 16'h0012, 16'h0015, 16'h001B,
        16'h0029, 16'h0031, 16'h0032, 16'h0016, 16'h3374, 16'h000F, 16'h0011, 16'h0018,
        16'h001C
    };
    localparam logic [31*16-1:0] CURVE_TAB = {
        16'h0000, 16'h0017, 16'h0018, 16'h001D, 16'h0019, 16'h11EC, 16'h001E, 16'h0100,
        16'h0101, 16'h0102, 16'h0103, 16'h0104, 16'h6399, 16'h0016, 16'h0009, 16'h000B,
        16'h000A, 16'h000C, 16'h000D, 16'h000E, 16'h001A, 16'h001B, 16'h001C, 16'h0015,
        16'h0013, 16'h0001, 16'h0003, 16'hFE32, 16'h11EB, 16'h11ED, 16'h4138
    };
    localparam logic [4*8-1:0] PF_TAB = {8'hFF, 8'h00, 8'h01, 8'h02};

    // Register step taken before a directed row
    typedef enum logic [1:0] {CFG_KEEP, CFG_OFF, CFG_ON} t_cfg_step;

    typedef struct packed {
        t_cfg_step           cfg;
        t_in_item            item;
        logic                typed;
        logic [BITMAP_W-1:0] bits;
        logic [15:0]         cnt;
        logic                mark;
    } t_dir_row;

    // DUT signals; the inputs are known from time zero
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor state
    logic [BITMAP_W-1:0] anchor_bits = '0;
    logic [COUNT_W-1:0]  value_tally = '0;
    logic                grease_on   = 1'b0;
    t_out_item           words_due[$];
    t_out_item           head_word;
    t_dir_row            dir_rows[$];

    int  miss_count = 0;
    int  words_seen = 0;
    bit  calm       = 1'b0;

    tls_hello_anchor_bitmap u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_miss(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        miss_count++;
        if (miss_count <= 40) begin
            $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
        end
    endtask

    function automatic int table_size(input logic [SEC_W-1:0] sec);
        case (sec)
            SEC_CIPHER: return 66;
            SEC_EXT:    return 25;
            SEC_CURVE:  return 31;
            default:    return 4;
        endcase
    endfunction

    function automatic logic [15:0] table_entry(input logic [SEC_W-1:0] sec, input int idx);
        case (sec)
            SEC_CIPHER: return CIPHER_TAB[(65 - idx) * 16 +: 16];
            SEC_EXT:    return EXT_TAB[(24 - idx) * 16 +: 16];
            SEC_CURVE:  return CURVE_TAB[(30 - idx) * 16 +: 16];
            default:    return {8'h00, PF_TAB[(3 - idx) * 8 +: 8]};
        endcase
    endfunction

    // Lowest matching index from 1 up, else 0
    function automatic int anchor_slot(input logic [SEC_W-1:0] sec, input logic [15:0] v);
        int hit;
        hit = 0;
        for (int i = table_size(sec) - 1; i >= 1; i--) begin
            if (table_entry(sec, i) == v) hit = i;
        end
        return hit;
    endfunction

    function automatic logic grease_code(input logic [15:0] v);
        return (v[3:0] == 4'hA) && (v[11:8] == 4'hA) && (v[15:8] == v[7:0]);
    endfunction

    function automatic t_in_item mk_item(input logic [SEC_W-1:0] sec, input logic [15:0] v,
                                         input logic empty, input logic grease,
                                         input logic last);
        t_in_item it;
        it.cmd             = sec;
        it.item_value      = v;
        it.list_empty      = empty;
        it.list_had_grease = grease;
        it.last_of_list    = last;
        return it;
    endfunction

    // One section end: cipher gives two words, the rest one
    task automatic queue_section_words(input logic [SEC_W-1:0] sec,
                                       input logic [BITMAP_W-1:0] bits,
                                       input logic [15:0] cnt, input logic mark);
        t_out_item w;
        w.out_section = sec;
        w.word_index  = 1'b0;
        w.bitmap_word = bits[63:0];
        w.value_count = cnt;
        w.grease_mark = mark;
        w.last_word   = (sec != SEC_CIPHER);
        words_due = {words_due, w};
        if (sec == SEC_CIPHER) begin
            w.word_index  = 1'b1;
            w.bitmap_word = {62'b0, bits[65:64]};
            w.last_word   = 1'b1;
            words_due = {words_due, w};
        end
    endtask

    // Predictor: fold one transferred item into the bitmap and count
    task automatic absorb_value(input t_in_item it, input bit push);
        logic [15:0] key;
        logic        mark;
        int unsigned t;
        key = (it.cmd == SEC_PF) ? {8'h00, it.item_value[7:0]} : it.item_value;
        if (it.list_empty) begin
            if (it.cmd == SEC_PF) anchor_bits[0] = 1'b1;
        end else if (it.cmd == SEC_PF || !grease_code(it.item_value)) begin
            if (value_tally != {COUNT_W{1'b1}}) value_tally = value_tally + COUNT_W'(1);
            anchor_bits[POS_W'(anchor_slot(it.cmd, key))] = 1'b1;
        end
        if (it.last_of_list) begin
            mark = (it.cmd != SEC_PF) && grease_on && it.list_had_grease;
            t = 32'(value_tally);
            if (push) queue_section_words(it.cmd, anchor_bits, (t > 65535) ? 16'hFFFF : t[15:0],
                                          mark);
            anchor_bits = '0;
            value_tally = '0;
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input t_in_item it, input bit typed,
                             input logic [BITMAP_W-1:0] bits, input logic [15:0] cnt,
                             input logic mark);
        while (!calm && $urandom_range(99) < 12) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_data  <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        absorb_value(it, !typed);
        if (typed && it.last_of_list) queue_section_words(it.cmd, bits, cnt, mark);
        @(negedge i_clk);
    endtask

    // Drain, then write grease_marking and read it back
    task automatic set_marking(input logic on);
        logic [APB_DATA_W-1:0] data;
        data       = $urandom;
        data[0]    = on;
        i_in_valid <= 1'b0;
        while (words_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_GREASE_MARKING;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {{(APB_DATA_W-1){1'b0}}, on}) begin
            report_miss("grease_marking readback", 64'(prdata), 64'(on));
        end
        @(negedge i_clk);
        psel      <= 1'b0;
        penable   <= 1'b0;
        grease_on = on;
    endtask

    // Mostly anchors and GREASE, the rest arbitrary
    function automatic logic [15:0] pick_value(input logic [SEC_W-1:0] sec);
        logic [15:0] e;
        logic [3:0]  nib;
        int          r;
        r = $urandom_range(99);
        if (r < 40) begin
            e = table_entry(sec, $urandom_range(table_size(sec) - 1));
            if (sec == SEC_PF) e[15:8] = 8'($urandom);
        end else if (r < 55) begin
            nib = 4'($urandom);
            e   = {nib, 4'hA, nib, 4'hA};
        end else begin
            e = 16'($urandom);
        end
        return e;
    endfunction

    // A random section, with some mixed-in sections and stray empty marks
    task automatic send_section(output int sent);
        logic [SEC_W-1:0] sec;
        logic [SEC_W-1:0] c;
        logic [15:0]      v;
        int               len;
        sec = SEC_W'($urandom_range(3));
        if ($urandom_range(99) < 8) len = 0;
        else if ($urandom_range(99) < 10) len = $urandom_range(40, 13);
        else len = $urandom_range(12, 1);
        if (len == 0) begin
            v = 16'($urandom);
            send_item(mk_item(sec, v, 1'b1, 1'($urandom_range(1)), 1'b1), 1'b0, '0, '0, 1'b0);
            sent = 1;
        end else begin
            for (int k = 0; k < len; k++) begin
                c = (k < len - 1 && $urandom_range(99) < 8) ? SEC_W'($urandom_range(3)) : sec;
                send_item(mk_item(c, pick_value(c), $urandom_range(99) < 3,
                                  1'($urandom_range(1)), k == len - 1), 1'b0, '0, '0, 1'b0);
            end
            sent = len;
        end
    endtask

    task automatic add_row(input t_cfg_step cfg, input logic [SEC_W-1:0] sec,
                           input logic [15:0] v, input logic empty, input logic grease,
                           input logic last, input logic typed,
                           input logic [BITMAP_W-1:0] bits, input logic [15:0] cnt,
                           input logic mark);
        t_dir_row row;
        row.cfg   = cfg;
        row.item  = mk_item(sec, v, empty, grease, last);
        row.typed = typed;
        row.bits  = bits;
        row.cnt   = cnt;
        row.mark  = mark;
        dir_rows = {dir_rows, row};
    endtask

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            words_seen++;
            if (words_due.size() == 0) begin
                report_miss("result with none due", o_out_data.bitmap_word, 64'h0);
            end else begin
                head_word = words_due.pop_front();
                if (o_out_data.out_section !== head_word.out_section)
                    report_miss("out_section", 64'(o_out_data.out_section),
                                64'(head_word.out_section));
                if (o_out_data.word_index !== head_word.word_index)
                    report_miss("word_index", 64'(o_out_data.word_index),
                                64'(head_word.word_index));
                if (o_out_data.bitmap_word !== head_word.bitmap_word)
                    report_miss("bitmap_word", o_out_data.bitmap_word, head_word.bitmap_word);
                if (o_out_data.value_count !== head_word.value_count)
                    report_miss("value_count", 64'(o_out_data.value_count),
                                64'(head_word.value_count));
                if (o_out_data.grease_mark !== head_word.grease_mark)
                    report_miss("grease_mark", 64'(o_out_data.grease_mark),
                                64'(head_word.grease_mark));
                if (o_out_data.last_word !== head_word.last_word)
                    report_miss("last_word", 64'(o_out_data.last_word),
                                64'(head_word.last_word));
            end
        end
    end

    // Receiver: random ready, one long hold-off once results are flowing
    initial begin
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else if (!held && words_seen >= 60) begin
                held        = 1'b1;
                hold_left   = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= calm || ($urandom_range(99) >= 12);
            end
        end
    end

    // Watchdog on cycles without any transfer
    initial begin
        int stuck;
        stuck = 0;
        while (stuck < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (psel && penable && pready)) stuck = 0;
            else stuck++;
        end
        $display("tls_hello_anchor_bitmap_test: done, errors");
        $finish;
    end

    // Stimulus
    initial begin
        t_dir_row row;
        int       issued;
        int       n;

        // Empty lists, table extremes, GREASE drop, marking off
        add_row(CFG_OFF,  SEC_PF,     16'hBEEF, 1, 1, 1, 1, 66'h1, 16'd0, 0);
        add_row(CFG_KEEP, SEC_CIPHER, 16'hFFFF, 1, 0, 1, 1, 66'h0, 16'd0, 0);
        add_row(CFG_KEEP, SEC_EXT,    16'hFFFF, 0, 0, 1, 1, 66'h1, 16'd1, 0);
        add_row(CFG_KEEP, SEC_CURVE,  16'h0A0A, 0, 1, 1, 1, 66'h0, 16'd0, 0);
        add_row(CFG_KEEP, SEC_CIPHER, 16'h0000, 0, 0, 0, 0, '0, '0, 0);
        add_row(CFG_KEEP, SEC_CIPHER, 16'h1304, 0, 0, 0, 0, '0, '0, 0);
        add_row(CFG_KEEP, SEC_CIPHER, 16'hC02F, 0, 0, 0, 0, '0, '0, 0);
        add_row(CFG_KEEP, SEC_CIPHER, 16'hFAFA, 0, 0, 0, 0, '0, '0, 0);
        add_row(CFG_KEEP, SEC_CIPHER, 16'hC032, 0, 1, 1, 1, 66'h3_0000_0000_0000_0003,
                16'd4, 0);
        // Point formats never drop values and look at the low byte only
        add_row(CFG_KEEP, SEC_PF,     16'h00FF, 0, 0, 0, 0, '0, '0, 0);
        add_row(CFG_KEEP, SEC_PF,     16'h0102, 0, 0, 0, 0, '0, '0, 0);
        add_row(CFG_KEEP, SEC_PF,     16'h1A1A, 0, 1, 1, 0, '0, '0, 0);
        // Mixed sections share one bitmap
        add_row(CFG_KEEP, SEC_EXT,    16'h001C, 0, 0, 0, 0, '0, '0, 0);
        add_row(CFG_KEEP, SEC_CURVE,  16'h4138, 0, 0, 0, 0, '0, '0, 0);
        add_row(CFG_KEEP, SEC_CIPHER, 16'h0A0A, 0, 0, 0, 0, '0, '0, 0);
        add_row(CFG_KEEP, SEC_PF,     16'h0001, 1, 0, 0, 0, '0, '0, 0);
        add_row(CFG_KEEP, SEC_EXT,    16'h0000, 0, 1, 1, 0, '0, '0, 0);
        // Marking on: flag counts only on the last item, never for point formats
        add_row(CFG_ON,   SEC_CURVE,  16'h11EC, 0, 1, 1, 1, 66'h20, 16'd1, 1);
        add_row(CFG_KEEP, SEC_PF,     16'h0000, 0, 1, 1, 1, 66'h2, 16'd1, 0);
        add_row(CFG_KEEP, SEC_EXT,    16'hFF01, 0, 1, 0, 0, '0, '0, 0);
        add_row(CFG_KEEP, SEC_EXT,    16'h3374, 0, 0, 1, 0, '0, '0, 0);
        add_row(CFG_KEEP, SEC_CIPHER, 16'hFFFF, 0, 1, 1, 1, 66'h1, 16'd1, 1);
        add_row(CFG_KEEP, SEC_CURVE,  16'h2A2A, 0, 1, 0, 0, '0, '0, 0);
        add_row(CFG_KEEP, SEC_CURVE,  16'h5555, 1, 1, 1, 1, 66'h0, 16'd0, 1);

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            if (row.cfg != CFG_KEEP) set_marking(row.cfg == CFG_ON);
            send_item(row.item, row.typed, row.bits, row.cnt, row.mark);
        end

        // Random sections in phases of alternating marking; phase 3 runs without gaps
        for (int ph = 0; ph < 6; ph++) begin
            set_marking(ph % 2 == 0);
            calm   = (ph == 3);
            issued = 0;
            while (issued < 150) begin
                send_section(n);
                issued += n;
            end
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        while (words_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (miss_count == 0) begin
            $display("tls_hello_anchor_bitmap_test: done, clean");
        end else begin
            $display("tls_hello_anchor_bitmap_test: done, errors");
        end
        $finish;
    end

endmodule
`default_nettype wire
